@@ hdl/llsa_pkg.sv @@
// Shared types and constants for the least-loaded slot allocator.
`default_nettype none

package llsa_pkg;

   localparam int ID_W       = 8;
   localparam int LOAD_W     = 8;
   localparam int CNT_W      = 4;
   localparam int TABLE_W    = 64;
   localparam int TBL_IDX_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int STATUS_W   = 3;

   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEVICE_COUNT     = 2'd0,
      CSR_SLOTS_PER_DEVICE = 2'd1,
      CSR_DEVICE_TABLE     = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED  = 3'd0,
      STATUS_BUSY     = 3'd1,
      STATUS_INACTIVE = 3'd2,
      STATUS_RELEASED = 3'd3,
      STATUS_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Operands of one scan step handed to the shared compare unit.
   typedef struct packed {
      logic [LOAD_W-1:0] load;
      logic [LOAD_W-1:0] best_load;
      logic              found;
      logic [LOAD_W-1:0] slots;
      logic [ID_W-1:0]   entry_id;
      logic [ID_W-1:0]   dev;
   } step_in_type;

   typedef struct packed {
      logic take;
      logic hit;
   } step_out_type;

endpackage

`default_nettype wire

@@ hdl/llsa_req_if.sv @@
// Request channel: acquire or release transactions.
`default_nettype none

interface llsa_req_if
   import llsa_pkg::*;
();
   logic            valid;
   logic            ready;
   logic            req_type;
   logic [ID_W-1:0] release_device;

   modport source (output valid, output req_type, output release_device, input ready);
   modport sink   (input valid, input req_type, input release_device, output ready);
endinterface

`default_nettype wire

@@ hdl/llsa_rsp_if.sv @@
// Response channel: status and granted device identifier.
`default_nettype none

interface llsa_rsp_if
   import llsa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     granted_device;

   modport source (output valid, output status, output granted_device, input ready);
   modport sink   (input valid, input status, input granted_device, output ready);
endinterface

`default_nettype wire

@@ hdl/llsa_csr_if.sv @@
// Configuration write channel: register index and write data.
`default_nettype none

interface llsa_csr_if
   import llsa_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TABLE_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/llsa_cmp.sv @@
// Shared compare unit used once per scan step.
`default_nettype none

module llsa_cmp
   import llsa_pkg::*;
(
   input  step_in_type  step_in,
   output step_out_type step_out
);

   // An entry is a better acquire candidate if it has a free slot and is
   // strictly lighter than the best so far, so ties keep the lower entry.
   assign step_out.take = (step_in.load < step_in.slots) &&
                          (!step_in.found || (step_in.load < step_in.best_load));
   assign step_out.hit  = (step_in.entry_id == step_in.dev) && (step_in.load != '0);

endmodule

`default_nettype wire

@@ hdl/least_loaded_slot_allocator.sv @@
// Top level of the least-loaded slot allocator: sequencer, load counters, CSRs.
//
//   channel   dir   handshake       payload
//   req_ch    in    valid/ready     req_type, release_device
//   rsp_ch    out   valid/ready     status, granted_device
//   csr_ch    in    valid/ready     index, data
//
// A transaction is accepted while idle, then the sequencer visits one table
// entry per cycle through the shared compare unit; an acquire scans all n
// valid entries (n at most MAX_DEVICES) before its response is shown, and a
// release stops at its first matching entry with a nonzero load. An inactive
// pool answers from idle without a scan. The response register holds until
// taken; no new request is accepted meanwhile. Reset clears all load counters at once.
`default_nettype none

module least_loaded_slot_allocator
   import llsa_pkg::*;
#(
   parameter int MAX_DEVICES = 8
) (
   input  wire         clock,
   input  wire         reset,
   llsa_req_if.sink    req_ch,
   llsa_rsp_if.source  rsp_ch,
   llsa_csr_if.sink    csr_ch
);

   localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEVICES);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    device_count_ff;
   logic [LOAD_W-1:0]   slots_ff;
   logic [TABLE_W-1:0]  device_table_ff;
   logic [LOAD_W-1:0]   load_ff [MAX_DEVICES];

   logic                type_ff, type_in;
   logic [ID_W-1:0]     dev_ff, dev_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]    last_idx_ff, last_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [LOAD_W-1:0]   best_load_ff, best_load_in;
   logic [ID_W-1:0]     best_id_ff, best_id_in;
   status_type          status_ff, status_in;
   logic [ID_W-1:0]     granted_ff, granted_in;

   logic [CNT_W-1:0]     valid_n;
   logic [LOAD_W-1:0]    cur_load;
   logic [TBL_IDX_W-1:0] id_sel;
   logic [ID_W-1:0]      cur_id;
   logic                 load_we;
   logic [IDX_W-1:0]     load_wa;
   logic [LOAD_W-1:0]    load_wd;
   step_in_type          step_in;
   step_out_type         step_out;

   assign valid_n  = (device_count_ff > MAX_CNT) ? MAX_CNT : device_count_ff;
   assign cur_load = load_ff[scan_idx_ff];
   assign id_sel   = TBL_IDX_W'(scan_idx_ff);
   assign cur_id   = device_table_ff[{id_sel, 3'b000} +: ID_W];

   assign step_in.load      = cur_load;
   assign step_in.best_load = best_load_ff;
   assign step_in.found     = found_ff;
   assign step_in.slots     = slots_ff;
   assign step_in.entry_id  = cur_id;
   assign step_in.dev       = dev_ff;

   llsa_cmp u_cmp (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = (state_ff == ST_RESP);
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.granted_device = granted_ff;
   assign csr_ch.ready         = 1'b1;

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      dev_in       = dev_ff;
      scan_idx_in  = scan_idx_ff;
      last_idx_in  = last_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_load_in = best_load_ff;
      best_id_in   = best_id_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      load_we      = 1'b0;
      load_wa      = scan_idx_ff;
      load_wd      = cur_load;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               type_in     = req_ch.req_type;
               dev_in      = req_ch.release_device;
               last_idx_in = IDX_W'(valid_n - CNT_W'(1));
               scan_idx_in = '0;
               found_in    = 1'b0;
               granted_in  = '0;
               if (valid_n == '0) begin
                  status_in = (req_ch.req_type == REQ_ACQUIRE) ? STATUS_INACTIVE
                                                                : STATUS_IGNORED;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (type_ff == REQ_ACQUIRE) begin
               if (step_out.take) begin
                  best_idx_in  = scan_idx_ff;
                  best_load_in = cur_load;
                  best_id_in   = cur_id;
                  found_in     = 1'b1;
               end
               if (scan_idx_ff == last_idx_ff) begin
                  state_in = ST_RESP;
                  if (found_in) begin
                     load_we    = 1'b1;
                     load_wa    = best_idx_in;
                     load_wd    = best_load_in + LOAD_W'(1);
                     status_in  = STATUS_GRANTED;
                     granted_in = best_id_in;
                  end else begin
                     status_in = STATUS_BUSY;
                  end
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end else begin
               if (step_out.hit) begin
                  load_we   = 1'b1;
                  load_wd   = cur_load - LOAD_W'(1);
                  status_in = STATUS_RELEASED;
                  state_in  = ST_RESP;
               end else if (scan_idx_ff == last_idx_ff) begin
                  status_in = STATUS_IGNORED;
                  state_in  = ST_RESP;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_count_ff <= '0;
         slots_ff        <= LOAD_W'(1);
         device_table_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DEVICE_COUNT:     device_count_ff <= csr_ch.data[CNT_W-1:0];
            CSR_SLOTS_PER_DEVICE: slots_ff        <= csr_ch.data[LOAD_W-1:0];
            CSR_DEVICE_TABLE:     device_table_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DEVICES; i++) begin
            load_ff[i] <= '0;
         end
      end else if (load_we) begin
         load_ff[load_wa] <= load_wd;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      dev_ff       <= dev_in;
      scan_idx_ff  <= scan_idx_in;
      last_idx_ff  <= last_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_load_ff <= best_load_in;
      best_id_ff   <= best_id_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
   end

   // A device identifier is only reported together with a grant.
   a_grant_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STATUS_GRANTED)) |-> (rsp_ch.granted_device == '0))
      else $error("granted_device nonzero without a grant");

   // The sequencer never walks past the last valid entry.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= last_idx_ff))
      else $error("scan index beyond last valid entry");

   // An acquire never answers with a release status.
   a_acquire_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (type_ff == REQ_ACQUIRE)) |->
         ((rsp_ch.status == STATUS_GRANTED) || (rsp_ch.status == STATUS_BUSY) ||
          (rsp_ch.status == STATUS_INACTIVE)))
      else $error("acquire answered with a release status");

   // A response is never shown while a new request can be accepted.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted while a response is pending");

endmodule

`default_nettype wire
